### rtl/bmsf_pkg.sv
// Types and constants shared by the brace message slot framer.
`timescale 1ns / 1ps
package bmsf_pkg;

	localparam logic [1:0] KIND_RX      = 2'd0;
	localparam logic [1:0] KIND_RELEASE = 2'd1;
	localparam logic [1:0] KIND_READ    = 2'd2;

	localparam logic [7:0] OPEN_BRACE  = 8'h7B;
	localparam logic [7:0] CLOSE_BRACE = 8'h7D;
	localparam logic [7:0] CHAR_F      = 8'h46;
	localparam logic [7:0] CHAR_L      = 8'h4C;
	localparam logic [7:0] CHAR_C      = 8'h43;
	localparam logic [7:0] CHAR_D      = 8'h44;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_W     = $clog2(QUEUE_DEPTH);

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] rx_byte;
		logic [2:0] slot_sel;
		logic [5:0] byte_offset;
	} item_t;

	typedef struct packed {
		logic       reply_valid;
		logic [7:0] reply_char;
		logic       message_done;
		logic [2:0] done_slot;
		logic [6:0] done_length;
		logic [7:0] read_data;
		logic       bypass_flag;
		logic       overflow;
		logic       pool_full;
		logic [3:0] ready_count;
	} result_t;

	typedef enum logic [1:0] {
		OP_RX,
		OP_RELEASE,
		OP_READ,
		OP_NONE
	} op_t;

	typedef struct packed {
		op_t        op;
		logic       is_open;
		logic       is_close;
		logic [7:0] rx_byte;
		logic [2:0] slot_sel;
		logic [5:0] byte_offset;
	} cls_item_t;

	typedef enum logic [1:0] {
		ST_LISTENING,
		ST_CAPTURING,
		ST_FULL
	} fsm_state_t;

endpackage

### rtl/bmsf_front.sv
// Front stage: takes transactions in and classifies them for the queue.
`timescale 1ns / 1ps
module bmsf_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  bmsf_pkg::item_t    item,
	input  logic               q_full,
	output logic               push,
	output bmsf_pkg::cls_item_t cls
);
	import bmsf_pkg::*;

	logic      valid_s1;
	cls_item_t cls_s1;
	cls_item_t cls_d;
	logic      accept;

	assign item_stall = valid_s1 && q_full;
	assign accept     = item_valid && !item_stall;
	assign push       = valid_s1 && !q_full;
	assign cls        = cls_s1;

	always_comb begin
		cls_d.rx_byte     = item.rx_byte;
		cls_d.slot_sel    = item.slot_sel;
		cls_d.byte_offset = item.byte_offset;
		cls_d.is_open     = (item.rx_byte == OPEN_BRACE);
		cls_d.is_close    = (item.rx_byte == CLOSE_BRACE);
		case (item.kind)
			KIND_RX:      cls_d.op = OP_RX;
			KIND_RELEASE: cls_d.op = OP_RELEASE;
			KIND_READ:    cls_d.op = OP_READ;
			default:      cls_d.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cls_s1 <= cls_d;
		end
	end

endmodule

### rtl/bmsf_queue.sv
// Short queue of classified transactions between front and back.
`timescale 1ns / 1ps
module bmsf_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  bmsf_pkg::cls_item_t push_data,
	input  logic                pop,
	output logic                full,
	output logic                q_valid,
	output bmsf_pkg::cls_item_t head
);
	import bmsf_pkg::*;

	cls_item_t            arr_q [QUEUE_DEPTH];
	logic [QUEUE_W-1:0]   wr_ptr_q;
	logic [QUEUE_W-1:0]   rd_ptr_q;
	logic [QUEUE_W:0]     count_q;

	assign full    = (count_q == (QUEUE_W+1)'(QUEUE_DEPTH));
	assign q_valid = (count_q != '0);
	assign head    = arr_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			arr_q[wr_ptr_q] <= push_data;
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (QUEUE_W+1)'(QUEUE_DEPTH))
		else $error("queue count beyond depth");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("push into full queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push) |=> count_q == $past(count_q) - 1'b1)
		else $error("queue count lost on pop");
`endif

endmodule

### rtl/bmsf_back.sv
// Back stage: framer state, slot pool, message store and result register.
`timescale 1ns / 1ps
module bmsf_back #(
	parameter int SLOTS      = 8,
	parameter int SLOT_BYTES = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_write_en,
	input  logic                cfg_write_data,
	input  logic                q_valid,
	input  bmsf_pkg::cls_item_t x,
	output logic                pop,
	output logic                result_valid,
	input  logic                result_stall,
	output bmsf_pkg::result_t   result
);
	import bmsf_pkg::*;

	localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int POS_W     = $clog2(SLOT_BYTES);
	localparam int CNT_W     = $clog2(SLOTS + 1);
	localparam int MEM_DEPTH = SLOTS * SLOT_BYTES;
	localparam int ADDR_W    = $clog2(MEM_DEPTH);

	logic [7:0]        mem [MEM_DEPTH];

	fsm_state_t        state_q;
	fsm_state_t        state_d;
	fsm_state_t        st_entry;
	logic              cap_en_q;
	logic [SLOTS-1:0]  slot_ready_q;
	logic [SLOT_W-1:0] capture_slot_q;
	logic [POS_W-1:0]  capture_pos_q;
	logic [CNT_W-1:0]  ready_total_q;
	logic [CNT_W-1:0]  ready_total_d;

	logic              res_valid_q;
	result_t           res_q;
	result_t           res_d;
	logic              rd_ok_q;
	logic [7:0]        mem_rd_q;

	logic              exec;
	logic              is_rx;
	logic              tot_full;
	logic              free_found;
	logic [SLOT_W-1:0] free_idx;
	logic              claim;
	logic              cap_now;
	logic [SLOT_W-1:0] slot_cur;
	logic [POS_W-1:0]  pos_cur;
	logic [POS_W:0]    pos_next;
	logic              ovf;
	logic              store_wr;
	logic              done;
	logic              sel_ok;
	logic [SLOT_W-1:0] sel_idx;
	logic [POS_W-1:0]  off_idx;
	logic              rel_ok;
	logic              rd_ok;
	logic [ADDR_W-1:0] wr_addr;
	logic [ADDR_W-1:0] rd_addr;

	assign exec = q_valid && (!res_valid_q || !result_stall);
	assign pop  = exec;

	assign result_valid = res_valid_q;
	always_comb begin
		result           = res_q;
		result.read_data = rd_ok_q ? mem_rd_q : 8'd0;
	end

	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!slot_ready_q[i]) begin
				free_found = 1'b1;
				free_idx   = SLOT_W'(i);
			end
		end
	end

	assign is_rx    = (x.op == OP_RX) && cap_en_q;
	assign tot_full = (32'(ready_total_q) >= SLOTS);
	assign st_entry = tot_full ? ST_FULL :
		((state_q == ST_FULL) ? ST_LISTENING : state_q);
	assign claim    = (st_entry == ST_LISTENING) && x.is_open && free_found;
	assign cap_now  = claim || (st_entry == ST_CAPTURING);
	assign slot_cur = claim ? free_idx : capture_slot_q;
	assign pos_cur  = claim ? '0 : capture_pos_q;
	assign pos_next = {1'b0, pos_cur} + 1'b1;
	assign ovf      = is_rx && cap_now && !x.is_close &&
		(pos_cur == POS_W'(SLOT_BYTES - 1));
	assign store_wr = is_rx && cap_now && !ovf;
	assign done     = store_wr && x.is_close;

	assign sel_ok  = (32'(x.slot_sel) < SLOTS);
	assign sel_idx = SLOT_W'(x.slot_sel);
	assign off_idx = POS_W'(x.byte_offset);
	assign rel_ok  = (x.op == OP_RELEASE) && sel_ok && slot_ready_q[sel_idx];
	assign rd_ok   = (x.op == OP_READ) && sel_ok && (32'(x.byte_offset) < SLOT_BYTES);
	assign wr_addr = ADDR_W'(slot_cur) * ADDR_W'(SLOT_BYTES) + ADDR_W'(pos_cur);
	assign rd_addr = ADDR_W'(sel_idx) * ADDR_W'(SLOT_BYTES) + ADDR_W'(off_idx);

	assign ready_total_d = done ? ready_total_q + 1'b1 :
		(rel_ok ? ready_total_q - 1'b1 : ready_total_q);

	// next state
	always_comb begin
		state_d = state_q;
		if (is_rx) begin
			case (st_entry)
				ST_FULL: begin
					state_d = ST_FULL;
				end
				ST_LISTENING: begin
					if (!x.is_open) begin
						state_d = ST_LISTENING;
					end else if (!free_found) begin
						state_d = ST_FULL;
					end else begin
						state_d = ST_CAPTURING;
					end
				end
				ST_CAPTURING: begin
					state_d = (ovf || x.is_close) ? ST_LISTENING : ST_CAPTURING;
				end
				default: begin
					state_d = ST_LISTENING;
				end
			endcase
		end
	end

	// result of this transaction
	always_comb begin
		res_d              = '0;
		res_d.bypass_flag  = (x.op == OP_RX) && !cap_en_q;
		res_d.overflow     = ovf;
		res_d.message_done = done;
		if (done) begin
			res_d.done_slot   = 3'(slot_cur);
			res_d.done_length = 7'(pos_next);
		end
		if (is_rx) begin
			if (tot_full) begin
				res_d.reply_valid = 1'b1;
				res_d.reply_char  = CHAR_F;
			end else if (st_entry == ST_LISTENING && !x.is_open) begin
				res_d.reply_valid = 1'b1;
				res_d.reply_char  = CHAR_L;
			end else if (store_wr) begin
				res_d.reply_valid = 1'b1;
				res_d.reply_char  = x.is_close ? CHAR_D : CHAR_C;
			end
		end
		res_d.pool_full   = (state_d == ST_FULL);
		res_d.ready_count = 4'(ready_total_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_en_q       <= 1'b1;
			state_q        <= ST_LISTENING;
			slot_ready_q   <= '0;
			capture_slot_q <= '0;
			capture_pos_q  <= '0;
			ready_total_q  <= '0;
			res_valid_q    <= 1'b0;
		end else begin
			if (cfg_write_en) begin
				cap_en_q <= cfg_write_data;
			end
			if (exec) begin
				res_valid_q   <= 1'b1;
				state_q       <= state_d;
				ready_total_q <= ready_total_d;
				if (claim && is_rx) begin
					capture_slot_q <= free_idx;
				end
				if (store_wr && !x.is_close) begin
					capture_pos_q <= pos_next[POS_W-1:0];
				end
				if (done) begin
					slot_ready_q[slot_cur] <= 1'b1;
				end
				if (rel_ok) begin
					slot_ready_q[sel_idx] <= 1'b0;
				end
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			res_q   <= res_d;
			rd_ok_q <= rd_ok;
		end
	end

	always_ff @(posedge clk) begin
		if (exec && store_wr) begin
			mem[wr_addr] <= x.rx_byte;
		end
		if (exec && rd_ok) begin
			mem_rd_q <= mem[rd_addr];
		end
	end

`ifndef SYNTHESIS
	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		32'(ready_total_q) == $countones(slot_ready_q))
		else $error("ready count out of step with slot flags");
	a_capture_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CAPTURING) |-> !slot_ready_q[capture_slot_q])
		else $error("capturing into a ready slot");
	a_done_reply: assert property (@(posedge clk) disable iff (!arst_n)
		(exec && done) |=> (res_q.reply_char == CHAR_D) && res_q.reply_valid
			&& (state_q == ST_LISTENING))
		else $error("completed message without done reply");
`endif

endmodule

### rtl/brace_message_slot_framer.sv
// Top level of the brace message slot framer.
// A transaction is registered in the front stage, held in the queue, and its result is registered in the back stage.
// Throughput: one transaction per cycle while neither item_stall nor result_stall holds, one result per transaction.
// The slot lookup, store write and store read are all done in the same back-stage cycle.
// Reset: listening, all slots free, count zero, capture enabled.
// Reset leaves message store contents undefined; no clearing pass is run.
`timescale 1ns / 1ps
module brace_message_slot_framer #(
	parameter int SLOTS      = 8,
	parameter int SLOT_BYTES = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_write_en,
	input  logic              cfg_write_data,
	input  logic              item_valid,
	output logic              item_stall,
	input  bmsf_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_stall,
	output bmsf_pkg::result_t result
);
	import bmsf_pkg::*;

	cls_item_t front_cls;
	cls_item_t q_head;
	logic      push;
	logic      pop;
	logic      q_full;
	logic      q_valid;

	bmsf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.q_full     (q_full),
		.push       (push),
		.cls        (front_cls)
	);

	bmsf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (front_cls),
		.pop       (pop),
		.full      (q_full),
		.q_valid   (q_valid),
		.head      (q_head)
	);

	bmsf_back #(
		.SLOTS      (SLOTS),
		.SLOT_BYTES (SLOT_BYTES)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.q_valid        (q_valid),
		.x              (q_head),
		.pop            (pop),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.result         (result)
	);

endmodule
